@@ hdl/modem_link_message_watcher_macros.svh @@
// assertion macros used by the watcher emitter
`ifndef MODEM_LINK_MESSAGE_WATCHER_MACROS_SVH
`define MODEM_LINK_MESSAGE_WATCHER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define MLMW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mlmw assertion failed");
// next-cycle implication, checked out of reset
`define MLMW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mlmw assertion failed");
`else
`define MLMW_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define MLMW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/mlmw_pkg.sv @@
`default_nettype none

package mlmw_pkg;

    // capture buffer
    localparam int CAPTURE_DEPTH = 64;
    localparam int CAP_IDX_W     = $clog2(CAPTURE_DEPTH + 1);
    localparam int SLOT_W        = 6;

    // message lengths
    localparam logic [3:0] NC_LEN = 4'd14;
    localparam logic [3:0] CN_LEN = 4'd11;

    localparam logic [7:0] CR_CHAR = 8'd13;

    // message texts, padded with zeros
    localparam logic [7:0] NC_MSG [16] = '{
        8'd13, 8'd10, 8'h4E, 8'h4F, 8'h20, 8'h43, 8'h41, 8'h52,
        8'h52, 8'h49, 8'h45, 8'h52, 8'd13, 8'd10, 8'd0, 8'd0
    };
    localparam logic [7:0] CN_MSG [16] = '{
        8'd13, 8'd10, 8'h43, 8'h4F, 8'h4E, 8'h4E, 8'h45, 8'h43,
        8'h54, 8'd13, 8'd10, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };

    // function codes
    localparam logic [1:0] FUNC_BYTE     = 2'd0;
    localparam logic [1:0] FUNC_SET_MODE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR    = 2'd2;

    // link modes
    localparam logic [2:0] MODE_NOT_STARTED = 3'd0;
    localparam logic [2:0] MODE_SLEEP       = 3'd1;
    localparam logic [2:0] MODE_ADVERTISE   = 3'd2;
    localparam logic [2:0] MODE_CONNECT     = 3'd3;
    localparam logic [2:0] MODE_SERIAL      = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_FORWARD = 2'd0;
    localparam logic [1:0] KIND_CAPTURE = 2'd1;
    localparam logic [1:0] KIND_EVENT   = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
        logic       link_pin_high;
        logic       command_mode;
        logic [2:0] new_mode;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        data_byte;
        logic [SLOT_W-1:0] capture_slot;
        logic [2:0]        link_mode;
        logic              flush_receive;
        logic              flush_transmit;
        logic              wake_pin_level;
        logic              last;
    } out_item_t;

    // what one request will emit, handed from tracker to emitter
    typedef struct packed {
        logic              cap;
        logic              fwd;
        logic              nc_ev;
        logic              cn_ev;
        logic [3:0]        prefix_len;
        logic [7:0]        data_byte;
        logic [SLOT_W-1:0] slot;
        logic [2:0]        final_mode;
        logic [2:0]        cn_mode;
        logic [4:0]        count;
    } plan_t;

endpackage

`default_nettype wire

@@ hdl/mlmw_in_if.sv @@
`default_nettype none

interface mlmw_in_if import mlmw_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/mlmw_out_if.sv @@
`default_nettype none

interface mlmw_out_if import mlmw_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/modem_link_message_watcher.sv @@
// pipeline: an accepted request's plan is registered in the emitter, then each
//   result in the output register; a request with n results (n up to 15) is
//   stepped out by the emitter one result per cycle unless the output stalls,
//   and no new request is taken meanwhile; one with no results leaves it idle
// reset: async active low; mode not started, both match counters and the
//   capture index cleared at once, no clearing pass
`default_nettype none

module modem_link_message_watcher import mlmw_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    mlmw_in_if.sink     feed,
    mlmw_out_if.source  result
);

    plan_t plan;
    logic  busy;
    logic  take;

    // one request at a time while results are stepped out
    assign feed.ready = !busy;
    assign take       = feed.valid && feed.ready;

    mlmw_tracker u_tracker (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (feed.data),
        .plan  (plan)
    );

    mlmw_emitter u_emitter (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (take),
        .plan_in (plan),
        .busy    (busy),
        .result  (result)
    );

endmodule

`default_nettype wire

@@ hdl/mlmw_tracker.sv @@
`default_nettype none

module mlmw_tracker import mlmw_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     take,
    input  in_item_t item,
    output plan_t    plan
);

    logic [2:0]           mode_reg, mode_next;
    logic [3:0]           nc_cnt_reg, nc_cnt_next;
    logic [3:0]           cn_cnt_reg, cn_cnt_next;
    logic [CAP_IDX_W-1:0] cap_idx_reg, cap_idx_next;
    logic                 watching;
    logic [2:0]           cn_mode;

    assign watching = (mode_reg == MODE_ADVERTISE) || (mode_reg == MODE_CONNECT) ||
                      (mode_reg == MODE_SERIAL);
    assign cn_mode  = item.link_pin_high ? MODE_CONNECT : MODE_SERIAL;

    // decide next state and the results of this request
    always_comb
    begin
        mode_next       = mode_reg;
        nc_cnt_next     = nc_cnt_reg;
        cn_cnt_next     = cn_cnt_reg;
        cap_idx_next    = cap_idx_reg;
        plan            = '0;
        plan.data_byte  = item.rx_byte;
        plan.slot       = SLOT_W'(cap_idx_reg);
        plan.cn_mode    = cn_mode;
        case (item.func)
            FUNC_BYTE:
            begin
                if (item.command_mode)
                begin
                    if (cap_idx_reg < CAP_IDX_W'(CAPTURE_DEPTH))
                    begin
                        plan.cap     = 1'b1;
                        cap_idx_next = cap_idx_reg + CAP_IDX_W'(1);
                    end
                end
                else if (watching)
                begin
                    // no carrier matcher
                    if (item.rx_byte == NC_MSG[nc_cnt_reg])
                        nc_cnt_next = nc_cnt_reg + 4'd1;
                    else if (item.rx_byte == CR_CHAR)
                        nc_cnt_next = 4'd1;
                    else if (mode_reg == MODE_SERIAL)
                    begin
                        plan.prefix_len = nc_cnt_reg;
                        plan.fwd        = 1'b1;
                        nc_cnt_next     = 4'd0;
                    end
                    // connect matcher
                    if (item.rx_byte == CN_MSG[cn_cnt_reg])
                        cn_cnt_next = cn_cnt_reg + 4'd1;
                    else if (item.rx_byte == CR_CHAR)
                        cn_cnt_next = 4'd1;
                    // completed messages
                    if (nc_cnt_next >= NC_LEN)
                    begin
                        plan.nc_ev  = 1'b1;
                        mode_next   = MODE_SLEEP;
                        nc_cnt_next = 4'd0;
                    end
                    if (cn_cnt_next >= CN_LEN)
                    begin
                        plan.cn_ev  = 1'b1;
                        mode_next   = cn_mode;
                        cn_cnt_next = 4'd0;
                    end
                end
            end
            FUNC_SET_MODE:
            begin
                if (item.new_mode <= MODE_SERIAL)
                    mode_next = item.new_mode;
            end
            FUNC_CLEAR:
            begin
                cap_idx_next = '0;
            end
            default:
            begin
            end
        endcase
        plan.final_mode = mode_next;
        plan.count      = 5'(plan.prefix_len) + 5'(plan.fwd) + 5'(plan.cap) +
                          5'(plan.nc_ev) + 5'(plan.cn_ev);
    end

    // link state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NOT_STARTED;
            nc_cnt_reg  <= 4'd0;
            cn_cnt_reg  <= 4'd0;
            cap_idx_reg <= '0;
        end
        else if (take)
        begin
            mode_reg    <= mode_next;
            nc_cnt_reg  <= nc_cnt_next;
            cn_cnt_reg  <= cn_cnt_next;
            cap_idx_reg <= cap_idx_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/mlmw_emitter.sv @@
`default_nettype none

`include "modem_link_message_watcher_macros.svh"

module mlmw_emitter import mlmw_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  plan_t             plan_in,
    output logic              busy,
    mlmw_out_if.source        result
);

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'b01,
        SEQ_EMIT = 2'b10
    } seq_state_t;

    seq_state_t state_reg, state_next;
    logic [3:0] step_reg, step_next;
    plan_t      plan_reg;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_item_reg;
    out_item_t  item;
    logic       load;
    logic [3:0] base;

    assign busy = (state_reg == SEQ_EMIT);
    assign load = busy && (!out_valid_reg || result.ready);
    assign base = plan_reg.prefix_len + 4'(plan_reg.fwd);

    // build the result for the current step
    always_comb
    begin
        item                = '0;
        item.kind           = KIND_FORWARD;
        item.link_mode      = plan_reg.final_mode;
        item.last           = ({1'b0, step_reg} == (plan_reg.count - 5'd1));
        if (plan_reg.cap)
        begin
            item.kind         = KIND_CAPTURE;
            item.data_byte    = plan_reg.data_byte;
            item.capture_slot = plan_reg.slot;
        end
        else if (step_reg < plan_reg.prefix_len)
            item.data_byte = NC_MSG[step_reg];
        else if (plan_reg.fwd && (step_reg == plan_reg.prefix_len))
            item.data_byte = plan_reg.data_byte;
        else if (plan_reg.nc_ev && (step_reg == base))
        begin
            item.kind           = KIND_EVENT;
            item.link_mode      = MODE_SLEEP;
            item.flush_transmit = 1'b1;
            item.wake_pin_level = 1'b1;
        end
        else
        begin
            item.kind           = KIND_EVENT;
            item.link_mode      = plan_reg.cn_mode;
            item.flush_receive  = 1'b1;
            item.flush_transmit = 1'b1;
        end
    end

    // step sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (result.ready)
            out_valid_next = 1'b0;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (start && (plan_in.count != 5'd0))
                begin
                    state_next = SEQ_EMIT;
                    step_next  = 4'd0;
                end
            end
            SEQ_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    step_next      = step_reg + 4'd1;
                    if (item.last)
                        state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (start)
            plan_reg <= plan_in;
        if (load)
            out_item_reg <= item;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_item_reg;

    `MLMW_ASSERT_NOW(a_step_in_range, clk, rst_n, busy, ({1'b0, step_reg} < plan_reg.count))
    `MLMW_ASSERT_NEXT(a_start_emits, clk, rst_n, start && (plan_in.count != 5'd0), busy)
    `MLMW_ASSERT_NEXT(a_last_ends, clk, rst_n, load && item.last, !busy && out_valid_reg)
    `MLMW_ASSERT_NOW(a_no_start_busy, clk, rst_n, busy, !start)

endmodule

`default_nettype wire

@@ test/tb.sv @@
`default_nettype none

module tb;
    import mlmw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 420;
    localparam int NC_TEXT_LEN     = 14;
    localparam int CN_TEXT_LEN     = 11;
    localparam int SETTLE_CYCLES   = 40;

    // function code with no meaning to the watcher
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // link message texts, zero padded
    localparam logic [7:0] NC_TEXT [16] = '{
        8'h0D, 8'h0A, "N", "O", " ", "C", "A", "R",
        "R", "I", "E", "R", 8'h0D, 8'h0A, 8'h00, 8'h00
    };
    localparam logic [7:0] CN_TEXT [16] = '{
        8'h0D, 8'h0A, "C", "O", "N", "N", "E", "C",
        "T", 8'h0D, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    logic clk = 1'b0;
    logic rst_n;

    mlmw_in_if  feed ();
    mlmw_out_if result ();

    modem_link_message_watcher dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed),
        .result (result)
    );

    // requests waiting for the driver, results waiting for the monitor
    in_item_t  pending_requests [$];
    out_item_t link_results_q [$];

    // watcher state as predicted
    logic [2:0] mode_q;
    int         nc_count;
    int         cn_count;
    int         capture_idx;

    int idle_pct  = 0;
    int stall_pct = 0;
    int sent_cnt;
    int useful_cnt;
    int result_cnt;
    int event_cnt;
    int capture_cnt;
    int fail_cnt;

    out_item_t want;
    out_item_t got;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // expected results of one accepted request; returns 0 for an unused code or an ignored byte, else 1
    function automatic bit predict_link_results(in_item_t req);
        out_item_t outs [$];
        bit        is_ev [$];
        out_item_t r;
        bit        effective;
        effective = 1'b0;
        if (req.func == FUNC_SET_MODE)
        begin
            if (req.new_mode <= MODE_SERIAL)
                mode_q = req.new_mode;
            return 1'b1;
        end
        if (req.func == FUNC_CLEAR)
        begin
            capture_idx = 0;
            return 1'b1;
        end
        if (req.func != FUNC_BYTE)
            return 1'b0;

        if (req.command_mode)
        begin
            // capture at a saturating index
            if (capture_idx < CAPTURE_DEPTH)
            begin
                r = '0;
                r.kind = KIND_CAPTURE;
                r.data_byte = req.rx_byte;
                r.capture_slot = capture_idx[SLOT_W-1:0];
                outs.push_back(r);
                is_ev.push_back(1'b0);
                capture_idx++;
                effective = 1'b1;
            end
        end
        else if (mode_q >= MODE_ADVERTISE && mode_q <= MODE_SERIAL)
        begin
            effective = 1'b1;
            // no carrier tracking, with pass-through of withheld bytes in serial mode
            if (req.rx_byte == NC_TEXT[nc_count & 15])
                nc_count++;
            else if (req.rx_byte == 8'h0D)
                nc_count = 1;
            else if (mode_q == MODE_SERIAL)
            begin
                for (int i = 0; i < nc_count; i++)
                begin
                    r = '0;
                    r.kind = KIND_FORWARD;
                    r.data_byte = NC_TEXT[i];
                    outs.push_back(r);
                    is_ev.push_back(1'b0);
                end
                nc_count = 0;
                r = '0;
                r.kind = KIND_FORWARD;
                r.data_byte = req.rx_byte;
                outs.push_back(r);
                is_ev.push_back(1'b0);
            end

            // connect tracking
            if (req.rx_byte == CN_TEXT[cn_count & 15])
                cn_count++;
            else if (req.rx_byte == 8'h0D)
                cn_count = 1;

            // completed messages, no carrier first
            if (nc_count >= NC_TEXT_LEN)
            begin
                mode_q = MODE_SLEEP;
                nc_count = 0;
                r = '0;
                r.kind = KIND_EVENT;
                r.link_mode = MODE_SLEEP;
                r.flush_transmit = 1'b1;
                r.wake_pin_level = 1'b1;
                outs.push_back(r);
                is_ev.push_back(1'b1);
            end
            if (cn_count >= CN_TEXT_LEN)
            begin
                mode_q = req.link_pin_high ? MODE_CONNECT : MODE_SERIAL;
                cn_count = 0;
                r = '0;
                r.kind = KIND_EVENT;
                r.link_mode = mode_q;
                r.flush_receive = 1'b1;
                r.flush_transmit = 1'b1;
                outs.push_back(r);
                is_ev.push_back(1'b1);
            end
            nc_count &= 15;
            cn_count &= 15;
        end

        // non-event results carry the mode after the whole request
        foreach (outs[k])
        begin
            if (!is_ev[k])
                outs[k].link_mode = mode_q;
            outs[k].last = (k == outs.size() - 1);
            link_results_q.push_back(outs[k]);
        end
        return effective;
    endfunction

    function automatic void check_field(string name, int want_v, int got_v);
        if (want_v != got_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
            fail_cnt++;
        end
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feed.valid <= 1'b0;
            feed.data  <= '0;
        end
        else if (!feed.valid || feed.ready)
        begin
            if (feed.valid)
            begin
                sent_cnt++;
                if (predict_link_results(feed.data))
                    useful_cnt++;
            end
            if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                feed.valid <= 1'b1;
                feed.data  <= pending_requests.pop_front();
            end
            else
                feed.valid <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
        begin
            if (result.valid && result.ready)
            begin
                got = result.data;
                if (link_results_q.size() == 0)
                begin
                    $error("unexpected result: kind %0d byte %0d", got.kind, got.data_byte);
                    fail_cnt++;
                end
                else
                begin
                    want = link_results_q.pop_front();
                    check_field("kind", want.kind, got.kind);
                    check_field("data_byte", want.data_byte, got.data_byte);
                    check_field("capture_slot", want.capture_slot, got.capture_slot);
                    check_field("link_mode", want.link_mode, got.link_mode);
                    check_field("flush_receive", want.flush_receive, got.flush_receive);
                    check_field("flush_transmit", want.flush_transmit, got.flush_transmit);
                    check_field("wake_pin_level", want.wake_pin_level, got.wake_pin_level);
                    check_field("last", want.last, got.last);
                    result_cnt++;
                    if (want.kind == KIND_EVENT)
                        event_cnt++;
                    if (want.kind == KIND_CAPTURE)
                        capture_cnt++;
                end
            end
            result.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic queue_request(logic [1:0] func, logic [7:0] rx, logic pin, logic cmd,
                                 logic [2:0] nm);
        in_item_t req;
        req.func = func;
        req.rx_byte = rx;
        req.link_pin_high = pin;
        req.command_mode = cmd;
        req.new_mode = nm;
        pending_requests.push_back(req);
    endtask

    task automatic queue_byte(logic [7:0] rx, logic cmd);
        queue_request(FUNC_BYTE, rx, 1'($urandom_range(1)), cmd, 3'($urandom_range(7)));
    endtask

    task automatic queue_mode(logic [2:0] nm);
        queue_request(FUNC_SET_MODE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), nm);
    endtask

    task automatic queue_clear();
        queue_request(FUNC_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), 3'($urandom_range(7)));
    endtask

    // the first count bytes of one link message
    task automatic queue_text(bit use_nc, int count);
        for (int i = 0; i < count; i++)
            queue_byte(use_nc ? NC_TEXT[i] : CN_TEXT[i], 1'b0);
    endtask

    // no carrier held one byte short while connect completes alongside it
    task automatic queue_overlap();
        queue_text(1'b1, 12);
        for (int i = 3; i <= 8; i++)
            queue_byte(CN_TEXT[i], 1'b0);
        queue_byte(8'h0D, 1'b0);
        queue_byte(8'h0A, 1'b0);
    endtask

    task automatic wait_drained();
        while (pending_requests.size() > 0 || feed.valid)
            @(posedge clk);
        while (link_results_q.size() > 0)
            @(posedge clk);
    endtask

    task automatic queue_phrase();
        int pick;
        int len;
        bit use_nc;
        pick = $urandom_range(99);
        use_nc = 1'($urandom_range(1));
        len = use_nc ? NC_TEXT_LEN : CN_TEXT_LEN;
        // bring the watcher back into a watching mode most of the time
        if ((mode_q < MODE_ADVERTISE || mode_q > MODE_SERIAL) && $urandom_range(9) < 8)
            queue_mode(3'($urandom_range(MODE_SERIAL, MODE_ADVERTISE)));
        if (pick < 28)
            queue_text(use_nc, len);
        else if (pick < 48)
        begin
            // broken message: a prefix and a stray byte
            queue_text(use_nc, $urandom_range(len - 1, 1));
            case ($urandom_range(3))
                0: queue_byte(8'h0D, 1'b0);
                1: queue_byte(8'h0A, 1'b0);
                default: queue_byte(8'($urandom_range(255)), 1'b0);
            endcase
        end
        else if (pick < 60)
        begin
            len = $urandom_range(6, 1);
            for (int i = 0; i < len; i++)
                queue_byte(8'($urandom_range(255)), 1'b0);
        end
        else if (pick < 74)
        begin
            if ($urandom_range(3) == 0)
                queue_mode(3'($urandom_range(7)));
            else
                queue_mode(3'($urandom_range(MODE_SERIAL, MODE_ADVERTISE)));
        end
        else if (pick < 86)
        begin
            // command session, now and then long enough to fill the capture buffer
            if ($urandom_range(3) == 0)
                queue_clear();
            len = ($urandom_range(4) == 0) ? $urandom_range(72, 40) : $urandom_range(10, 1);
            for (int i = 0; i < len; i++)
                queue_byte(8'($urandom_range(255)), 1'b1);
        end
        else if (pick < 91)
            queue_clear();
        else if (pick < 95)
        begin
            queue_mode($urandom_range(1) ? MODE_ADVERTISE : MODE_CONNECT);
            queue_overlap();
        end
        else
            queue_request(FUNC_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 3'($urandom_range(7)));
    endtask

    // stimulus and end of run
    initial
    begin
        int base;
        int phase;
        int prev_phase;
        mode_q = MODE_NOT_STARTED;
        nc_count = 0;
        cn_count = 0;
        capture_idx = 0;
        sent_cnt = 0;
        useful_cnt = 0;
        result_cnt = 0;
        event_cnt = 0;
        capture_cnt = 0;
        fail_cnt = 0;
        feed.valid = 1'b0;
        feed.data = '0;
        result.ready = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: ignored bytes, unused code, out of range mode
        queue_byte(8'h00, 1'b0);
        queue_request(FUNC_UNUSED, 8'hFF, 1'b1, 1'b1, 3'd7);
        queue_mode(3'd7);
        queue_mode(MODE_ADVERTISE);
        // both messages complete on one byte, link pin low
        queue_overlap();
        pending_requests[pending_requests.size() - 1].link_pin_high = 1'b0;
        // serial mode: withheld prefix released by a stray byte
        queue_text(1'b1, 4);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_clear();
        queue_byte(8'h00, 1'b1);
        wait_drained();

        // random: no idling, sender idle, receiver stalls, both
        base = sent_cnt;
        prev_phase = 0;
        while (sent_cnt - base < RANDOM_REQUESTS)
        begin
            phase = (sent_cnt - base) * 4 / RANDOM_REQUESTS;
            if (phase != prev_phase)
            begin
                if (phase == 2)
                    wait_drained();
                prev_phase = phase;
            end
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 75; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 75; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            queue_phrase();
            while (pending_requests.size() >= 4)
                @(posedge clk);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("sent %0d requests, %0d of them effective, giving %0d results",
                 sent_cnt, useful_cnt, result_cnt);
        $display("of those %0d link events and %0d captured bytes", event_cnt, capture_cnt);
        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #(20_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
